// File: hdl/png_scanline_unfilter_assert.svh
// Assertion macros shared by the PNG unfilter RTL.
// Expects signals named clk and rst in the including scope.
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PNGU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("png unfilter assertion failed");

// Next-cycle implication, checked outside reset.
`define PNGU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("png unfilter assertion failed");

`endif

// File: hdl/png_unf_pkg.sv
// Package for the PNG scanline unfilter: payload structs, filter and register codes.
// Used by every module of the block; has no dependencies.
package png_unf_pkg;

  localparam int MAX_LINE_PIXELS_DEF = 4096;
  localparam int IMAGE_WIDTH_W       = 13;
  localparam int PADDR_W             = 3;
  localparam int NUM_LANES           = 4;

  typedef enum logic [7:0] {
    FILT_NONE  = 8'd0,
    FILT_SUB   = 8'd1,
    FILT_UP    = 8'd2,
    FILT_AVG   = 8'd3,
    FILT_PAETH = 8'd4
  } filter_type_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH = 1'b0,
    REG_HAS_ALPHA   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] filter_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       end_of_line;
  } pix_out_t;

  typedef struct packed {
    logic has_alpha;
    logic end_of_line;
  } merge_ctrl_t;

endpackage

// File: hdl/png_unf_lane.sv
// One channel lane: reconstructs a single filtered byte from its left, upper and
// upper-left neighbors. Depends on png_unf_pkg.
module png_unf_lane (
  input  logic [7:0] filter_type,
  input  logic [7:0] x,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] c,
  output logic [7:0] y
);
  import png_unf_pkg::*;

  logic signed [10:0] d_pa;
  logic signed [10:0] d_pb;
  logic signed [10:0] d_pc;
  logic [10:0]        pa;
  logic [10:0]        pb;
  logic [10:0]        pc;
  logic [7:0]         paeth;
  logic [8:0]         sum_ab;
  logic [7:0]         pred;

  // p - a = b - c, p - b = a - c, p - c = a + b - 2c.
  always_comb begin
    d_pa = $signed({3'b000, b}) - $signed({3'b000, c});
    d_pb = $signed({3'b000, a}) - $signed({3'b000, c});
    d_pc = d_pa + d_pb;
    pa   = d_pa[10] ? 11'(-d_pa) : 11'(d_pa);
    pb   = d_pb[10] ? 11'(-d_pb) : 11'(d_pb);
    pc   = d_pc[10] ? 11'(-d_pc) : 11'(d_pc);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  assign sum_ab = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (filter_type)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
  end

  assign y = x + pred;

endmodule

// File: hdl/png_unf_line_store.sv
// Prior-line store: one write port and one read port with registered read data.
// Depends on png_unf_pkg for the default depth.
module png_unf_line_store #(
  parameter int DEPTH = png_unf_pkg::MAX_LINE_PIXELS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);
  import png_unf_pkg::*;

  logic [31:0] mem [DEPTH];

  // Read-first: a read and a write to one address in a cycle return the old word.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/png_unf_merge.sv
// Merging stage: combines the four lane bytes into the result transaction and the
// packed word kept for the next line. Depends on png_unf_pkg.
module png_unf_merge (
  input  logic [png_unf_pkg::NUM_LANES-1:0][7:0] lane_y,
  input  png_unf_pkg::merge_ctrl_t               ctrl,
  output png_unf_pkg::pix_out_t                  result,
  output logic [31:0]                            packed_word
);
  import png_unf_pkg::*;

  logic [7:0] alpha;

  // In RGB mode the alpha lane still runs but its byte is dropped everywhere.
  assign alpha = ctrl.has_alpha ? lane_y[3] : 8'd0;

  always_comb begin
    result.out_red     = lane_y[0];
    result.out_green   = lane_y[1];
    result.out_blue    = lane_y[2];
    result.out_alpha   = alpha;
    result.end_of_line = ctrl.end_of_line;
    packed_word        = {alpha, lane_y[2], lane_y[1], lane_y[0]};
  end

endmodule

// File: hdl/png_scanline_unfilter.sv
// PNG scanline unfilter for 8-bit RGB/RGBA pixels, top level.
// Depends on png_unf_pkg, png_unf_lane, png_unf_line_store, png_unf_merge.
//
// Usage: filtered pixels enter on the pixel channel (valid/ready), one per
// transaction, each with its scanline's filter byte; start_of_image marks the
// first pixel of an image. Reconstructed pixels leave on the result channel in
// order, one per input, with end_of_line on the last pixel of each scanline.
// image_width and has_alpha sit on the APB port at 0x0 and 0x4; the user must
// change them only while the block is idle, which the block itself does not enforce.
// An accepted pixel is registered in the compute stage, then in the result
// register that drives result_valid. Throughput is one pixel per clock while the
// receiver takes results: the four channel lanes, the Paeth select and the
// left-pixel feedback all settle within the compute stage, and the line store
// takes one read and one write per cycle, with a bypass when a pixel reads the
// entry its predecessor is writing (width of one pixel).
// When the receiver stalls, the result register holds and the compute stage
// fills; after that pixel_ready drops until the result is taken.
// Reset clears the pipeline, the column counter and the first-line flag and
// loads image_width = 1, has_alpha = 1. The line store needs no clearing: the
// first line never reads it.
`include "png_scanline_unfilter_assert.svh"

module png_scanline_unfilter #(
  parameter int MAX_LINE_PIXELS = png_unf_pkg::MAX_LINE_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  png_unf_pkg::pix_in_t            pixel,
  output logic                            result_valid,
  input  logic                            result_ready,
  output png_unf_pkg::pix_out_t           result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [png_unf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import png_unf_pkg::*;

  localparam int AW = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int CW = (AW + 1 > IMAGE_WIDTH_W) ? AW + 1 : IMAGE_WIDTH_W;

  // Configuration registers.
  logic [IMAGE_WIDTH_W-1:0] image_width;
  logic                     has_alpha;
  reg_idx_t                 reg_idx;
  logic                     cfg_write;

  // Column tracking.
  logic [AW-1:0] column;
  logic [AW-1:0] column_next;
  logic          on_first_line;
  logic          on_first_line_next;

  // Stage 0 decode of the incoming pixel.
  logic          accept;
  logic [AW-1:0] s0_col;
  logic          s0_first;
  logic          s0_eol;
  logic [CW-1:0] width_ext;
  logic [CW-1:0] width_sat;

  // Stage 1: compute.
  logic          s1_valid;
  pix_in_t       s1_pix;
  logic [AW-1:0] s1_col;
  logic          s1_first;
  logic          s1_eol;
  logic          s1_line_start;
  logic          s1_adv;
  logic          byp_hit;
  logic [31:0]   byp_data;
  logic [31:0]   rd_data;
  logic [31:0]   up_word;
  logic [31:0]   left_word;
  logic [31:0]   upleft_word;
  logic [31:0]   left_pixel;
  logic [31:0]   upper_left_pixel;
  logic [31:0]   packed_word;
  pix_out_t      s1_result;
  merge_ctrl_t   mctrl;

  logic [NUM_LANES-1:0][7:0] lane_x;
  logic [NUM_LANES-1:0][7:0] lane_y;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IMAGE_WIDTH_W'(1);
      has_alpha   <= 1'b1;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_IMAGE_WIDTH: image_width <= pwdata[IMAGE_WIDTH_W-1:0];
        REG_HAS_ALPHA:   has_alpha   <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH: prdata = 32'(image_width);
      REG_HAS_ALPHA:   prdata = 32'(has_alpha);
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------- handshake ----------------
  assign s1_adv      = s1_valid && (!result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_adv;
  assign accept      = pixel_valid && pixel_ready;

  // ---------------- stage 0: column and line tracking ----------------
  assign width_ext = CW'(image_width);

  always_comb begin
    if (width_ext == '0) begin
      width_sat = CW'(1);
    end else if (width_ext > CW'(MAX_LINE_PIXELS)) begin
      width_sat = CW'(MAX_LINE_PIXELS);
    end else begin
      width_sat = width_ext;
    end
  end

  always_comb begin
    s0_col   = pixel.start_of_image ? '0 : column;
    s0_first = pixel.start_of_image ? 1'b1 : on_first_line;
    // A column at or past the line end (width shrunk mid-line) also ends the line.
    s0_eol   = (CW'(s0_col) + CW'(1)) >= width_sat;
    column_next        = s0_eol ? '0 : s0_col + AW'(1);
    on_first_line_next = s0_eol ? 1'b0 : s0_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column        <= '0;
      on_first_line <= 1'b1;
    end else if (accept) begin
      column        <= column_next;
      on_first_line <= on_first_line_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // The store reads first, so a write landing on the address being read in the
  // same cycle is forwarded through the bypass register.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix        <= pixel;
      s1_col        <= s0_col;
      s1_first      <= s0_first;
      s1_eol        <= s0_eol;
      s1_line_start <= (s0_col == '0);
      byp_hit       <= s1_adv && (s1_col == s0_col);
      byp_data      <= packed_word;
    end
  end

  png_unf_line_store #(
    .DEPTH (MAX_LINE_PIXELS),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (packed_word),
    .rd_en   (accept),
    .rd_addr (s0_col),
    .rd_data (rd_data)
  );

  // ---------------- stage 1: lanes and merge ----------------
  always_comb begin
    if (s1_first) begin
      up_word = 32'd0;
    end else if (byp_hit) begin
      up_word = byp_data;
    end else begin
      up_word = rd_data;
    end
    left_word   = s1_line_start ? 32'd0 : left_pixel;
    upleft_word = s1_line_start ? 32'd0 : upper_left_pixel;
    lane_x[0]   = s1_pix.in_red;
    lane_x[1]   = s1_pix.in_green;
    lane_x[2]   = s1_pix.in_blue;
    lane_x[3]   = s1_pix.in_alpha;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    png_unf_lane u_lane (
      .filter_type (s1_pix.filter_type),
      .x           (lane_x[g]),
      .a           (left_word[8*g +: 8]),
      .b           (up_word[8*g +: 8]),
      .c           (upleft_word[8*g +: 8]),
      .y           (lane_y[g])
    );
  end

  assign mctrl.has_alpha   = has_alpha;
  assign mctrl.end_of_line = s1_eol;

  png_unf_merge u_merge (
    .lane_y      (lane_y),
    .ctrl        (mctrl),
    .result      (s1_result),
    .packed_word (packed_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= 32'd0;
      upper_left_pixel <= 32'd0;
    end else if (s1_adv) begin
      left_pixel       <= packed_word;
      upper_left_pixel <= up_word;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= s1_result;
    end
  end

  // ---------------- assertions ----------------
  `PNGU_ASSERT_NEXT(a_eol_restarts_column, accept && s0_eol, column == '0)
  `PNGU_ASSERT_NEXT(a_soi_first_line, accept && pixel.start_of_image && !s0_eol,
                    on_first_line)
  `PNGU_ASSERT_NEXT(a_compute_fills_output, s1_adv, result_valid)
  `PNGU_ASSERT_IMP(a_bypass_needs_prior_line, s1_valid && byp_hit && !s1_first,
                   s1_col == '0 || s1_line_start == 1'b0)

endmodule
